[rtl/csp_pkg.sv]
// Shared types and constants for the CSI sequence parser.
// Has no dependencies; csi_sequence_parser and csp_checker refer to it by scoped names.
package csp_pkg;

    // Request command codes.
    localparam logic CMD_SEQ  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_BYTE   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_READ   = 2'd3;

    // Characters that the parser recognises.
    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_BRACKET = 8'h5b;
    localparam logic [7:0] CH_SEMI    = 8'h3b;
    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    // One request: a sequence byte or a read of the stored sequence.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  seq_byte;
        logic        is_last;
        logic [2:0]  group_sel;
        logic [2:0]  index_sel;
        logic [31:0] fallback;
    } t_req;

    // One response.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  final_byte;
        logic [3:0]  group_total;
        logic        found;
        logic [31:0] read_value;
    } t_rsp;

endpackage

[rtl/csp_store.sv]
// Two-bank value store and per-group value counts of the CSI sequence parser.
// Both are synchronous memories with one write and one registered read port.
// Depends on nothing but its parameters.
module csp_store #(
    parameter int  MAX_GROUPS = 8,
    parameter int  MAX_VALUES = 8,
    parameter int  VALUE_BITS = 32,
    localparam int GIW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    localparam int VIW        = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
    localparam int CW         = $clog2(MAX_VALUES + 1),
    localparam int AW         = 1 + GIW + VIW,
    localparam int CAW        = 1 + GIW
) (
    input  logic                  i_clk,
    // Value store ports.
    input  logic                  i_val_we,
    input  logic [AW-1:0]         i_val_waddr,
    input  logic [VALUE_BITS-1:0] i_val_wdata,
    input  logic                  i_val_re,
    input  logic [AW-1:0]         i_val_raddr,
    output logic [VALUE_BITS-1:0] o_val_rdata,
    // Value count ports.
    input  logic                  i_cnt_we,
    input  logic [CAW-1:0]        i_cnt_waddr,
    input  logic [CW-1:0]         i_cnt_wdata,
    input  logic                  i_cnt_re,
    input  logic [CAW-1:0]        i_cnt_raddr,
    output logic [CW-1:0]         o_cnt_rdata
);

    logic [VALUE_BITS-1:0] r_val_mem [2**AW];
    logic [CW-1:0]         r_cnt_mem [2**CAW];
    logic [VALUE_BITS-1:0] r_val_rdata;
    logic [CW-1:0]         r_cnt_rdata;

    // Value store: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            r_val_mem[i_val_waddr] <= i_val_wdata;
        end
        if (i_val_re) begin
            r_val_rdata <= r_val_mem[i_val_raddr];
        end
    end

    // Value counts: write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cnt_we) begin
            r_cnt_mem[i_cnt_waddr] <= i_cnt_wdata;
        end
        if (i_cnt_re) begin
            r_cnt_rdata <= r_cnt_mem[i_cnt_raddr];
        end
    end

    assign o_val_rdata = r_val_rdata;
    assign o_cnt_rdata = r_cnt_rdata;

endmodule

[rtl/csi_sequence_parser.sv]
// Top level of the CSI escape sequence parser: byte parser, read path and output stage.
// Depends on csp_pkg and instantiates csp_store.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         i_req_valid / o_req_stall  i_req (csp_pkg::t_req)
//  response  out        o_rsp_valid / i_rsp_stall  o_rsp (csp_pkg::t_rsp)
//
// One request is accepted per cycle while o_req_stall is low; each gives exactly one
// response, registered by the store's read port and then by the output register.
// A byte updates the decimal accumulator and counters, and writes the store, in its
// accept cycle, so requests follow back to back with no interlock.
// Reset is synchronous and active low; the store needs no clearing pass.
// A stalled response holds; requests stall only when both pipeline stages are full.
module csi_sequence_parser #(
    parameter int MAX_GROUPS = 8,
    parameter int MAX_VALUES = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  csp_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output csp_pkg::t_rsp o_rsp
);

    localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int VIW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int GCW = $clog2(MAX_GROUPS + 1);
    localparam int CW  = $clog2(MAX_VALUES + 1);
    localparam int AW  = 1 + GIW + VIW;
    localparam int CAW = 1 + GIW;

    // Parser phases.
    localparam logic [1:0] PH_ESC     = 2'd0;
    localparam logic [1:0] PH_BRACKET = 2'd1;
    localparam logic [1:0] PH_BODY    = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    // What a request carries into the read stage.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  final_byte;
        logic [3:0]  group_total;
        logic        is_read;
        logic        grp_ok;
        logic [2:0]  index_sel;
        logic [31:0] fallback;
    } t_s1;

    // Parser state.
    logic [1:0]            r_phase, n_phase;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_has_dig, n_has_dig;
    logic                  r_seg_ne, n_seg_ne;
    logic [CW-1:0]         r_cur_cnt, n_cur_cnt;
    logic [GCW-1:0]        r_gcnt [2];
    logic [GCW-1:0]        n_gcnt [2];
    logic [7:0]            r_final [2];
    logic [7:0]            n_final [2];
    logic                  r_active, n_active;

    // Pipeline stages.
    logic                  r_s1_valid;
    t_s1                   r_s1, n_s1;
    logic                  r_o_valid;
    csp_pkg::t_rsp         r_o_rsp, s1_rsp;

    // Handshake.
    logic req_acc, out_free, s1_free;

    // Parser helpers.
    logic                  bank_b;
    logic                  dropping;
    logic                  is_digit;
    logic                  do_push, do_close;
    logic                  store_val;
    logic [CW-1:0]         cnt_after;
    logic [VALUE_BITS+3:0] acc_x, acc_next;
    logic                  acc_ovf;

    // Store ports.
    logic                  val_we, val_re, cnt_we, cnt_re;
    logic [AW-1:0]         val_waddr, val_raddr;
    logic [CAW-1:0]        cnt_waddr, cnt_raddr;
    logic [VALUE_BITS-1:0] val_rdata;
    logic [CW-1:0]         cnt_rdata;
    logic [GIW-1:0]        cur_gidx;
    logic                  read_found;

    assign out_free    = !r_o_valid || !i_rsp_stall;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_req_stall = !s1_free;
    assign req_acc     = i_req_valid && s1_free;

    // Decimal accumulator step: acc * 10 + digit, with the carry-out flagging overflow.
    assign acc_x    = {4'b0000, r_acc};
    assign acc_next = (acc_x << 3) + (acc_x << 1)
                    + {{VALUE_BITS{1'b0}}, i_req.seq_byte[3:0]};
    assign acc_ovf  = |acc_next[VALUE_BITS+3:VALUE_BITS];

    assign bank_b   = !r_active;
    assign dropping = r_gcnt[bank_b] >= GCW'(MAX_GROUPS);
    assign is_digit = i_req.seq_byte inside {[csp_pkg::CH_ZERO:csp_pkg::CH_NINE]};
    assign cur_gidx = GIW'(r_gcnt[bank_b]);

    // Byte parser: decides the phase change and which of push and close to do.
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_has_dig = r_has_dig;
        n_seg_ne  = r_seg_ne;
        n_cur_cnt = r_cur_cnt;
        n_gcnt    = r_gcnt;
        n_final   = r_final;
        n_active  = r_active;
        do_push   = 1'b0;
        do_close  = 1'b0;
        n_s1.status = csp_pkg::ST_BYTE;

        if (req_acc && i_req.cmd == csp_pkg::CMD_READ) begin
            n_s1.status = csp_pkg::ST_READ;
        end else if (req_acc) begin
            case (r_phase)
                PH_ESC: begin
                    if (i_req.is_last) begin
                        n_s1.status = csp_pkg::ST_REJECT;
                    end else if (i_req.seq_byte != csp_pkg::CH_ESC) begin
                        n_phase = PH_DISCARD;
                    end else begin
                        n_gcnt[bank_b] = '0;
                        n_cur_cnt      = '0;
                        n_phase        = PH_BRACKET;
                    end
                end
                PH_BRACKET: begin
                    if (i_req.is_last) begin
                        n_phase     = PH_ESC;
                        n_s1.status = csp_pkg::ST_REJECT;
                    end else if (i_req.seq_byte != csp_pkg::CH_BRACKET) begin
                        n_phase = PH_DISCARD;
                    end else begin
                        n_acc     = '0;
                        n_has_dig = 1'b0;
                        n_seg_ne  = 1'b0;
                        n_phase   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_req.is_last) begin
                        do_close        = r_seg_ne && !dropping;
                        n_final[bank_b] = i_req.seq_byte;
                        n_active        = bank_b;
                        n_phase         = PH_ESC;
                        n_s1.status     = csp_pkg::ST_ACCEPT;
                    end else if (i_req.seq_byte == csp_pkg::CH_SEMI) begin
                        do_close = !dropping;
                        n_seg_ne = 1'b0;
                    end else begin
                        n_seg_ne = 1'b1;
                        if (!dropping) begin
                            if (i_req.seq_byte == csp_pkg::CH_COLON) begin
                                if (!r_has_dig) begin
                                    n_phase = PH_DISCARD;
                                end else begin
                                    do_push = 1'b1;
                                end
                            end else if (is_digit) begin
                                if (acc_ovf) begin
                                    n_phase = PH_DISCARD;
                                end else begin
                                    n_acc     = acc_next[VALUE_BITS-1:0];
                                    n_has_dig = 1'b1;
                                end
                            end else begin
                                n_phase = PH_DISCARD;
                            end
                        end
                    end
                end
                default: begin
                    if (i_req.is_last) begin
                        n_phase     = PH_ESC;
                        n_s1.status = csp_pkg::ST_REJECT;
                    end
                end
            endcase
        end

        // Store the accumulated value while the group has room.
        store_val = (do_push || (do_close && r_has_dig))
                 && (r_cur_cnt < CW'(MAX_VALUES));
        cnt_after = store_val ? r_cur_cnt + CW'(1) : r_cur_cnt;

        if (do_push) begin
            n_cur_cnt = cnt_after;
            n_acc     = '0;
            n_has_dig = 1'b0;
        end

        // Closing a group writes its value count back and opens the next group.
        if (do_close) begin
            n_gcnt[bank_b] = r_gcnt[bank_b] + GCW'(1);
            n_cur_cnt      = '0;
            n_acc          = '0;
            n_has_dig      = 1'b0;
            n_seg_ne       = 1'b0;
        end

        n_s1.final_byte  = n_final[n_active];
        n_s1.group_total = 4'(n_gcnt[n_active]);
        n_s1.is_read     = i_req.cmd == csp_pkg::CMD_READ;
        n_s1.grp_ok      = 32'(i_req.group_sel) < 32'(r_gcnt[r_active]);
        n_s1.index_sel   = i_req.index_sel;
        n_s1.fallback    = i_req.fallback;
    end

    // Memory access: writes for the inactive bank, reads from the active bank.
    assign val_we    = store_val;
    assign val_waddr = {bank_b, cur_gidx, VIW'(r_cur_cnt)};
    assign cnt_we    = do_close;
    assign cnt_waddr = {bank_b, cur_gidx};
    assign val_re    = req_acc && i_req.cmd == csp_pkg::CMD_READ;
    assign cnt_re    = val_re;
    assign val_raddr = {r_active, GIW'(i_req.group_sel), VIW'(i_req.index_sel)};
    assign cnt_raddr = {r_active, GIW'(i_req.group_sel)};

    csp_store #(
        .MAX_GROUPS (MAX_GROUPS),
        .MAX_VALUES (MAX_VALUES),
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_val_we    (val_we),
        .i_val_waddr (val_waddr),
        .i_val_wdata (r_acc),
        .i_val_re    (val_re),
        .i_val_raddr (val_raddr),
        .o_val_rdata (val_rdata),
        .i_cnt_we    (cnt_we),
        .i_cnt_waddr (cnt_waddr),
        .i_cnt_wdata (cnt_after),
        .i_cnt_re    (cnt_re),
        .i_cnt_raddr (cnt_raddr),
        .o_cnt_rdata (cnt_rdata)
    );

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ESC;
            r_acc      <= '0;
            r_has_dig  <= 1'b0;
            r_seg_ne   <= 1'b0;
            r_cur_cnt  <= '0;
            r_gcnt[0]  <= '0;
            r_gcnt[1]  <= '0;
            r_final[0] <= '0;
            r_final[1] <= '0;
            r_active   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_has_dig  <= n_has_dig;
            r_seg_ne   <= n_seg_ne;
            r_cur_cnt  <= n_cur_cnt;
            r_gcnt[0]  <= n_gcnt[0];
            r_gcnt[1]  <= n_gcnt[1];
            r_final[0] <= n_final[0];
            r_final[1] <= n_final[1];
            r_active   <= n_active;
        end
    end

    // Read stage: waits for the memory read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= req_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1 <= n_s1;
        end
    end

    // Assemble the response from the read data.
    always_comb begin
        read_found         = r_s1.is_read && r_s1.grp_ok
                          && (32'(r_s1.index_sel) < 32'(cnt_rdata));
        s1_rsp.status      = r_s1.status;
        s1_rsp.final_byte  = r_s1.final_byte;
        s1_rsp.group_total = r_s1.group_total;
        s1_rsp.found       = read_found;
        if (read_found) begin
            s1_rsp.read_value = 32'(val_rdata);
        end else if (r_s1.is_read) begin
            s1_rsp.read_value = r_s1.fallback;
        end else begin
            s1_rsp.read_value = '0;
        end
    end

    // Output register: holds while the response is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_o_rsp <= s1_rsp;
        end
    end

    assign o_rsp_valid = r_o_valid;
    assign o_rsp       = r_o_rsp;

endmodule

[rtl/csp_checker.sv]
// Port-level checks of the CSI sequence parser and the bind that attaches them.
// Depends on csp_pkg; bound to csi_sequence_parser.
module csp_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input csp_pkg::t_req i_req,
    input logic          o_rsp_valid,
    input logic          i_rsp_stall,
    input csp_pkg::t_rsp o_rsp
);

    // A stalled response holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // Requests are held back only while a response is waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_stall |-> o_rsp_valid && i_rsp_stall)
        else $error("request stalled with a free output");

    // No response leaves in the first cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_rsp_valid)
        else $error("response valid straight after reset");

    // A byte that is only taken leaves the stored final byte as it was.
    a_byte_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_stall && o_rsp.status == csp_pkg::ST_BYTE
        |=> !o_rsp_valid || o_rsp.status == csp_pkg::ST_ACCEPT
            || o_rsp.final_byte == $past(o_rsp.final_byte))
        else $error("stored final byte changed without an accepted sequence");

endmodule

bind csi_sequence_parser csp_checker u_csp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_stall (i_rsp_stall),
    .o_rsp       (o_rsp)
);
